>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge once reset has been released
`define SPTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define SPTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/sptq_pkg.sv
`default_nettype none

package sptq_pkg;

  // table geometry
  localparam int MAX_PHASES    = 16;
  localparam int DURATION_BITS = 12;
  localparam int IDX_W         = $clog2(MAX_PHASES);
  localparam int PHASE_W       = $clog2(MAX_PHASES + 1);

  // field widths
  localparam int CFG_W  = 5;
  localparam int EIDX_W = 4;
  localparam int DUR_W  = 12;
  localparam int CUR_W  = 5;
  localparam int SUM_W  = 17;
  localparam int TOT_W  = 16;

  // accumulator wide enough for two full walks plus the time left
  localparam int ACC_W  = DURATION_BITS + IDX_W + 2;

  localparam logic [ACC_W-1:0] SUM_MAX = ACC_W'((64'd1 << SUM_W) - 64'd1);
  localparam logic [ACC_W-1:0] TOT_MAX = ACC_W'((64'd1 << TOT_W) - 64'd1);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                     green;
    logic [DURATION_BITS-1:0] dur;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOT,
    ST_W1,
    ST_W2,
    ST_DONE
  } state_e;

  // circular successor within the active plan
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                input logic [PHASE_W-1:0] n);
    logic [PHASE_W-1:0] s;
    s = PHASE_W'(i) + PHASE_W'(1);
    return (s >= n) ? '0 : IDX_W'(s);
  endfunction

  function automatic logic [ACC_W-1:0] sat(input logic [ACC_W-1:0] v,
                                           input logic [ACC_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/signal_phase_time_query_unit.sv
`default_nettype none
// Phase timing query unit. An item is taken when start_i is high and busy_o is low;
// req_type_i low stores one phase entry (duration and green flag) in the phase
// table, req_type_i high asks for the red and green times around the running
// phase. Every item gives exactly one result, shown for a single cycle with
// result_valid_o high; there is no back-pressure, so the receiver must take it
// then. Writes and rejected queries (empty plan or phase number out of range,
// bad_query_o set) answer in the cycle after the item is taken and leave busy_o
// low, so items may follow back to back. A valid query keeps busy_o high while the
// single read port of the phase table is swept: once for the total green sum over
// the active phases, then for the run of the current colour, and, when green, for
// the red run after it; a last state then forms the answer. The num_phases register
// is written through cfg_we_i / cfg_data_i; the user must write it only while idle,
// as the block itself does not enforce this.
`include "assert_macros.svh"

module signal_phase_time_query_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // configuration
  input  wire                           cfg_we_i,
  input  wire  [sptq_pkg::CFG_W-1:0]    cfg_data_i,
  // item
  input  wire                           start_i,
  output logic                          busy_o,
  input  wire                           req_type_i,
  input  wire  [sptq_pkg::EIDX_W-1:0]   entry_index_i,
  input  wire  [sptq_pkg::DUR_W-1:0]    entry_duration_i,
  input  wire                           entry_green_i,
  input  wire  [sptq_pkg::CUR_W-1:0]    current_phase_i,
  input  wire                           current_green_i,
  input  wire  [sptq_pkg::DUR_W-1:0]    time_left_i,
  // result
  output logic                          result_valid_o,
  output logic [sptq_pkg::SUM_W-1:0]    remaining_red_o,
  output logic [sptq_pkg::SUM_W-1:0]    next_red_o,
  output logic [sptq_pkg::SUM_W-1:0]    remaining_green_o,
  output logic [sptq_pkg::TOT_W-1:0]    total_green_o,
  output logic                          bad_query_o
);

  import sptq_pkg::*;

  // phase table: one synchronous memory, one read and one write per cycle
  entry_t mem [MAX_PHASES];
  entry_t rdata_q;

  state_e state_q, state_d;

  logic [CFG_W-1:0]   num_phases_q;
  logic [PHASE_W-1:0] n_eff;

  // query context held for the whole sweep
  logic               qgreen_q, qgreen_d;
  logic [DUR_W-1:0]   tl_q, tl_d;
  logic [IDX_W-1:0]   start_q, start_d;

  // read sequencer: address issued now, index of the data returning now
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [IDX_W-1:0]   didx_q;
  logic               dv_q, dv_d;
  logic [PHASE_W-1:0] cnt_q, cnt_d;

  logic [ACC_W-1:0]   tot_q, tot_d;
  logic [ACC_W-1:0]   run1_q, run1_d;
  logic [ACC_W-1:0]   run2_q, run2_d;

  // result register
  logic               rvalid_q, rvalid_d;
  logic [SUM_W-1:0]   rr_q, rr_d, nr_q, nr_d, rg_q, rg_d;
  logic [TOT_W-1:0]   tg_q, tg_d;
  logic               bad_q, bad_d;

  logic               accept, is_query, q_bad;
  logic               last, want, match, walk_end;
  logic [IDX_W-1:0]   stop_idx;
  logic [ACC_W-1:0]   rsum;

  // effective phase count, saturated to the table depth
  assign n_eff = (PHASE_W'(num_phases_q) > PHASE_W'(MAX_PHASES)) ?
                 PHASE_W'(MAX_PHASES) : PHASE_W'(num_phases_q);

  assign accept   = start_i && (state_q == ST_IDLE);
  assign is_query = (req_type_i == REQ_QUERY);
  assign q_bad    = (n_eff == '0) || (current_phase_i == '0) ||
                    (PHASE_W'(current_phase_i) > n_eff);

  // walk bookkeeping on the data returning this cycle
  assign last     = (cnt_q + PHASE_W'(1)) == n_eff;
  assign want     = (state_q == ST_W1) ? qgreen_q : 1'b0;
  assign match    = (rdata_q.green == want);
  assign walk_end = dv_q && (!match || last);
  // a mismatch stops on that entry, a full lap stops one past the last visited
  assign stop_idx = match ? next_idx(didx_q, n_eff) : didx_q;

  // --------------------------------------------------------------------------
  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_phases_q <= '0;
    end else if (cfg_we_i) begin
      num_phases_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // phase table; writes happen only when idle, so a sweep never meets a write
  always_ff @(posedge clk_i) begin
    if (accept && !is_query) begin
      mem[IDX_W'(entry_index_i)] <= '{green: entry_green_i,
                                     dur: DURATION_BITS'(entry_duration_i)};
    end
    rdata_q <= mem[addr_q];
  end

  // --------------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_query && !q_bad) begin
          state_d = ST_TOT;
        end
      end
      ST_TOT: begin
        if (dv_q && last) begin
          state_d = ST_W1;
        end
      end
      ST_W1: begin
        if (walk_end) begin
          state_d = qgreen_q ? ST_W2 : ST_DONE;
        end
      end
      ST_W2: begin
        if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath and outputs
  always_comb begin
    qgreen_d = qgreen_q;
    tl_d     = tl_q;
    start_d  = start_q;
    // reads step round the active plan, wrapping at its end
    addr_d   = next_idx(addr_q, n_eff);
    dv_d     = 1'b1;
    cnt_d    = cnt_q;
    tot_d    = tot_q;
    run1_d   = run1_q;
    run2_d   = run2_q;
    rvalid_d = 1'b0;
    rr_d     = rr_q;
    nr_d     = nr_q;
    rg_d     = rg_q;
    tg_d     = tg_q;
    bad_d    = bad_q;
    rsum     = run1_q + ACC_W'(tl_q);

    unique case (state_q)
      ST_IDLE: begin
        addr_d = '0;
        dv_d   = 1'b0;
        cnt_d  = '0;
        tot_d  = '0;
        if (accept) begin
          qgreen_d = current_green_i;
          tl_d     = time_left_i;
          // phase after the current one, wrapping at the plan end
          start_d  = (PHASE_W'(current_phase_i) == n_eff) ? '0 : IDX_W'(current_phase_i);
          if (!is_query || q_bad) begin
            // writes and rejected queries answer straight from idle, with no sweep
            rvalid_d = 1'b1;
            rr_d     = '0;
            nr_d     = '0;
            rg_d     = '0;
            tg_d     = '0;
            bad_d    = is_query;
          end
        end
      end
      ST_TOT: begin
        if (dv_q) begin
          if (rdata_q.green) begin
            tot_d = tot_q + ACC_W'(rdata_q.dur);
          end
          cnt_d = cnt_q + PHASE_W'(1);
          if (last) begin
            addr_d = start_q;
            dv_d   = 1'b0;
            cnt_d  = '0;
            run1_d = '0;
          end
        end
      end
      ST_W1: begin
        if (dv_q) begin
          if (match) begin
            run1_d = run1_q + ACC_W'(rdata_q.dur);
          end
          cnt_d = cnt_q + PHASE_W'(1);
          if (walk_end) begin
            addr_d = stop_idx;
            dv_d   = 1'b0;
            cnt_d  = '0;
            run2_d = '0;
          end
        end
      end
      ST_W2: begin
        if (dv_q) begin
          if (match) begin
            run2_d = run2_q + ACC_W'(rdata_q.dur);
          end
          cnt_d = cnt_q + PHASE_W'(1);
          if (walk_end) begin
            dv_d = 1'b0;
          end
        end
      end
      ST_DONE: begin
        dv_d     = 1'b0;
        rvalid_d = 1'b1;
        bad_d    = 1'b0;
        rr_d     = qgreen_q ? '0 : SUM_W'(sat(rsum, SUM_MAX));
        rg_d     = qgreen_q ? SUM_W'(sat(rsum, SUM_MAX)) : '0;
        nr_d     = qgreen_q ? SUM_W'(sat(run2_q, SUM_MAX)) : '0;
        tg_d     = TOT_W'(sat(tot_q, TOT_MAX));
      end
      default: begin
        dv_d = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dv_q     <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      dv_q     <= dv_d;
      rvalid_q <= rvalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    qgreen_q <= qgreen_d;
    tl_q     <= tl_d;
    start_q  <= start_d;
    addr_q   <= addr_d;
    didx_q   <= addr_q;
    cnt_q    <= cnt_d;
    tot_q    <= tot_d;
    run1_q   <= run1_d;
    run2_q   <= run2_d;
    rr_q     <= rr_d;
    nr_q     <= nr_d;
    rg_q     <= rg_d;
    tg_q     <= tg_d;
    bad_q    <= bad_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign result_valid_o    = rvalid_q;
  assign remaining_red_o   = rr_q;
  assign next_red_o        = nr_q;
  assign remaining_green_o = rg_q;
  assign total_green_o     = tg_q;
  assign bad_query_o       = bad_q;

  // --------------------------------------------------------------------------
  // assertions
  `SPTQ_ASSERT(a_write_answers, start_i && !busy_o && (req_type_i == REQ_WRITE) |=> result_valid_o && !busy_o && !bad_query_o, "write item did not answer next cycle")
  `SPTQ_ASSERT(a_empty_rejected, start_i && !busy_o && (req_type_i == REQ_QUERY) && (num_phases_q == '0) |=> result_valid_o && bad_query_o, "query on empty plan not rejected")
  `SPTQ_ASSERT(a_no_result_busy, busy_o |-> !result_valid_o, "result strobe while sweeping")
  `SPTQ_ASSERT(a_done_answers, (state_q == ST_DONE) |=> result_valid_o && !busy_o && !bad_query_o, "sweep end without result")
  `SPTQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !result_valid_o && !busy_o, "activity during reset")

endmodule

`default_nettype wire
